@@ sv/fur_pkg.sv @@
// Shared constants, codes and transaction types of the firmware update receiver.
`timescale 1ns / 1ps

package fur_pkg;

    // Default sizing
    localparam int CHUNK_BYTES = 128;
    localparam int QUEUE_DEPTH = 2;

    // Config port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_RETRY_LIMIT   = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
    localparam logic [1:0] REG_MAX_IMAGE     = 2'd2;

    localparam logic [7:0]  RETRY_LIMIT_RST   = 8'd3;
    localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd5000;
    localparam logic [24:0] MAX_IMAGE_RST     = 25'd65536;

    // Start payload carries size and CRC
    localparam logic [15:0] START_PAYLOAD_LEN = 16'd8;

    // Commands
    localparam logic [2:0] CMD_START  = 3'd0;
    localparam logic [2:0] CMD_DATA   = 3'd1;
    localparam logic [2:0] CMD_END    = 3'd2;
    localparam logic [2:0] CMD_VERIFY = 3'd3;
    localparam logic [2:0] CMD_REBOOT = 3'd4;
    localparam logic [2:0] CMD_ABORT  = 3'd5;

    // Response codes
    localparam logic [2:0] RC_OK     = 3'd0;
    localparam logic [2:0] RC_ERROR  = 3'd1;
    localparam logic [2:0] RC_CRC    = 3'd2;
    localparam logic [2:0] RC_SIZE   = 3'd3;
    localparam logic [2:0] RC_FLASH  = 3'd4;
    localparam logic [2:0] RC_RESEND = 3'd5;
    localparam logic [2:0] RC_VERIFY = 3'd6;

    // Phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_READY     = 3'd1;
    localparam logic [2:0] PH_RECEIVING = 3'd2;
    localparam logic [2:0] PH_VERIFY    = 3'd3;
    localparam logic [2:0] PH_COMPLETE  = 3'd4;
    localparam logic [2:0] PH_ERROR     = 3'd5;

    // Classified item handed from front to back
    typedef struct packed {
        logic        is_tick;
        logic [2:0]  command;
        logic        crc_ok;
        logic [15:0] seq;
        logic [15:0] payload_len;
        logic [31:0] image_size;
        logic [31:0] image_crc;
        logic        flash_ok;
        logic [31:0] computed_crc;
        logic        len_ok;
        logic        size_bad;
        logic [23:0] offset;
    } cls_t;

    // Result transaction
    typedef struct packed {
        logic [2:0]  resp_command;
        logic [2:0]  response_code;
        logic [15:0] resp_seq;
        logic        write_enable;
        logic [23:0] write_offset;
        logic        erase_enable;
        logic        reboot_request;
        logic [2:0]  phase_out;
    } res_t;

endpackage

@@ sv/firmware_update_receiver_fsm_unit.sv @@
// Top level of the firmware update receiver: config registers, front end and back end.
`timescale 1ns / 1ps
//
// Firmware update receiver phase controller.
// Input channel (push/full): one transaction is a framed update packet
// (kind = 0) or a timer tick (kind = 1). Accepted when push is high and
// full is low. A tick yields a result only when it triggers a timeout abort;
// every packet yields one result, except a data packet that exceeds the retry
// limit, which moves to the error phase without a result.
// Result channel (empty/pop): the oldest result sits on the resp_* ports
// while empty is low and is taken when pop is high.
// Pipeline: a transaction is written into the front queue at the accepting
// edge, executed by the phase sequencer once it heads that queue and a
// result slot is free, and its result is registered into the result queue.
// Throughput: one transaction per cycle while the result queue has room;
// the front and result queues (QUEUE_DEPTH entries each) decouple
// the two sides. If the consumer stops popping, the result queue fills,
// the sequencer stalls, then the front queue fills and full rises.
// Reset (rst_n low, async): phase idle, all counters zero, queues empty,
// registers retry_limit = 3, timeout_ticks = 5000, max_image_size = 65536.
// Config (APB, pready always high): 0x0 retry_limit, 0x4 timeout_ticks,
// 0x8 max_image_size; the user must write them only while no transaction
// is in flight, since the block itself does not enforce it.

module firmware_update_receiver_fsm_unit #(
    parameter int CHUNK_BYTES = fur_pkg::CHUNK_BYTES,
    parameter int QUEUE_DEPTH = fur_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB config port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fur_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fur_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fur_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // Input queue side
    input  logic                           push,
    output logic                           full,
    input  logic                           kind,
    input  logic [2:0]                     command,
    input  logic                           crc_ok,
    input  logic [15:0]                    seq,
    input  logic [15:0]                    payload_len,
    input  logic [31:0]                    image_size,
    input  logic [31:0]                    image_crc,
    input  logic                           flash_ok,
    input  logic [31:0]                    computed_crc,
    // Result queue side
    output logic                           empty,
    input  logic                           pop,
    output logic [2:0]                     resp_command,
    output logic [2:0]                     response_code,
    output logic [15:0]                    resp_seq,
    output logic                           write_enable,
    output logic [23:0]                    write_offset,
    output logic                           erase_enable,
    output logic                           reboot_request,
    output logic [2:0]                     phase_out
);

    logic [7:0]    retry_limit_reg;
    logic [31:0]   timeout_ticks_reg;
    logic [24:0]   max_image_size_reg;
    logic          cfg_wr;
    logic [1:0]    reg_idx;

    fur_pkg::cls_t cq_data;
    logic          cq_empty;
    logic          cq_pop;
    fur_pkg::res_t res_out;

    // Config registers; byte offset 4*index, low address bits ignored
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg    <= fur_pkg::RETRY_LIMIT_RST;
            timeout_ticks_reg  <= fur_pkg::TIMEOUT_TICKS_RST;
            max_image_size_reg <= fur_pkg::MAX_IMAGE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                fur_pkg::REG_RETRY_LIMIT:   retry_limit_reg    <= pwdata[7:0];
                fur_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg  <= pwdata;
                fur_pkg::REG_MAX_IMAGE:     max_image_size_reg <= pwdata[24:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            fur_pkg::REG_RETRY_LIMIT:   prdata = {24'd0, retry_limit_reg};
            fur_pkg::REG_TIMEOUT_TICKS: prdata = timeout_ticks_reg;
            fur_pkg::REG_MAX_IMAGE:     prdata = {7'd0, max_image_size_reg};
            default:                    prdata = '0;
        endcase
    end

    fur_front #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .kind           (kind),
        .command        (command),
        .crc_ok         (crc_ok),
        .seq            (seq),
        .payload_len    (payload_len),
        .image_size     (image_size),
        .image_crc      (image_crc),
        .flash_ok       (flash_ok),
        .computed_crc   (computed_crc),
        .max_image_size (max_image_size_reg),
        .cq_pop         (cq_pop),
        .cq_data        (cq_data),
        .cq_empty       (cq_empty)
    );

    fur_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cq_data       (cq_data),
        .cq_empty      (cq_empty),
        .cq_pop        (cq_pop),
        .retry_limit   (retry_limit_reg),
        .timeout_ticks (timeout_ticks_reg),
        .pop           (pop),
        .empty         (empty),
        .res_out       (res_out)
    );

    assign resp_command   = res_out.resp_command;
    assign response_code  = res_out.response_code;
    assign resp_seq       = res_out.resp_seq;
    assign write_enable   = res_out.write_enable;
    assign write_offset   = res_out.write_offset;
    assign erase_enable   = res_out.erase_enable;
    assign reboot_request = res_out.reboot_request;
    assign phase_out      = res_out.phase_out;

endmodule

@@ sv/fur_fifo.sv @@
// Small register-based FIFO used between the pipeline parts.
`timescale 1ns / 1ps

module fur_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = fur_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_fire, rd_fire;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign wr_fire = wr_en && !full;
    assign rd_fire = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr_fire, rd_fire})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ sv/fur_front.sv @@
// Front end: accepts input transactions, pre-classifies them and queues them.
`timescale 1ns / 1ps

module fur_front #(
    parameter int CHUNK_BYTES = fur_pkg::CHUNK_BYTES,
    parameter int QUEUE_DEPTH = fur_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                kind,
    input  logic [2:0]          command,
    input  logic                crc_ok,
    input  logic [15:0]         seq,
    input  logic [15:0]         payload_len,
    input  logic [31:0]         image_size,
    input  logic [31:0]         image_crc,
    input  logic                flash_ok,
    input  logic [31:0]         computed_crc,
    input  logic [24:0]         max_image_size,
    input  logic                cq_pop,
    output fur_pkg::cls_t       cq_data,
    output logic                cq_empty
);

    localparam int OFF_W = 24;

    fur_pkg::cls_t cls;

    // State-independent checks done here so the back end stays shallow
    always_comb
    begin
        cls.is_tick      = kind;
        cls.command      = command;
        cls.crc_ok       = crc_ok;
        cls.seq          = seq;
        cls.payload_len  = payload_len;
        cls.image_size   = image_size;
        cls.image_crc    = image_crc;
        cls.flash_ok     = flash_ok;
        cls.computed_crc = computed_crc;
        cls.len_ok       = (payload_len == fur_pkg::START_PAYLOAD_LEN);
        cls.size_bad     = (image_size == 32'd0) || (image_size > {7'd0, max_image_size});
        cls.offset       = OFF_W'(seq) * OFF_W'(CHUNK_BYTES);
    end

    fur_fifo #(
        .WIDTH ($bits(fur_pkg::cls_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls),
        .full    (full),
        .rd_en   (cq_pop),
        .rd_data (cq_data),
        .empty   (cq_empty)
    );

endmodule

@@ sv/fur_back.sv @@
// Back end: transfer phase sequencer and result queue.
`timescale 1ns / 1ps

module fur_back #(
    parameter int QUEUE_DEPTH = fur_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  fur_pkg::cls_t cq_data,
    input  logic          cq_empty,
    output logic          cq_pop,
    input  logic [7:0]    retry_limit,
    input  logic [31:0]   timeout_ticks,
    input  logic          pop,
    output logic          empty,
    output fur_pkg::res_t res_out
);

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] stored_size_reg, stored_size_next;
    logic [31:0] stored_crc_reg, stored_crc_next;
    logic [15:0] next_seq_reg, next_seq_next;
    logic [31:0] received_bytes_reg, received_bytes_next;
    logic [7:0]  retries_reg, retries_next;
    logic [31:0] idle_ticks_reg, idle_ticks_next;

    fur_pkg::res_t res;
    logic          has_res;
    logic          rq_full;
    logic          advance;
    logic [31:0]   ticks_inc;
    logic          active;

    // Take the next item only when a result slot is free
    assign advance = !cq_empty && !rq_full;
    assign cq_pop  = advance;
    assign active  = (phase_reg == fur_pkg::PH_READY) || (phase_reg == fur_pkg::PH_RECEIVING);
    assign ticks_inc = (idle_ticks_reg != 32'hFFFF_FFFF) ? idle_ticks_reg + 32'd1
                                                          : idle_ticks_reg;

    always_comb
    begin
        phase_next          = phase_reg;
        stored_size_next    = stored_size_reg;
        stored_crc_next     = stored_crc_reg;
        next_seq_next       = next_seq_reg;
        received_bytes_next = received_bytes_reg;
        retries_next        = retries_reg;
        idle_ticks_next     = idle_ticks_reg;
        has_res             = 1'b0;
        res                 = '0;

        if (cq_data.is_tick)
        begin
            if (active)
            begin
                if (ticks_inc > timeout_ticks)
                begin
                    phase_next          = fur_pkg::PH_IDLE;
                    stored_size_next    = '0;
                    stored_crc_next     = '0;
                    next_seq_next       = '0;
                    received_bytes_next = '0;
                    retries_next        = '0;
                    idle_ticks_next     = '0;
                    has_res             = 1'b1;
                    res.resp_command    = fur_pkg::CMD_ABORT;
                    res.response_code   = fur_pkg::RC_OK;
                end
                else
                begin
                    idle_ticks_next = ticks_inc;
                end
            end
        end
        else if (!cq_data.crc_ok)
        begin
            has_res           = 1'b1;
            res.resp_command  = cq_data.command;
            res.response_code = fur_pkg::RC_CRC;
            res.resp_seq      = next_seq_reg;
        end
        else
        begin
            has_res          = 1'b1;
            res.resp_command = cq_data.command;
            unique case (cq_data.command)
                fur_pkg::CMD_START:
                begin
                    if (!cq_data.len_ok)
                    begin
                        res.response_code = fur_pkg::RC_SIZE;
                    end
                    else
                    begin
                        stored_size_next = cq_data.image_size;
                        stored_crc_next  = cq_data.image_crc;
                        if (cq_data.size_bad)
                        begin
                            res.response_code = fur_pkg::RC_SIZE;
                        end
                        else
                        begin
                            next_seq_next       = '0;
                            received_bytes_next = '0;
                            retries_next        = '0;
                            idle_ticks_next     = '0;
                            res.erase_enable    = 1'b1;
                            if (!cq_data.flash_ok)
                            begin
                                phase_next        = fur_pkg::PH_ERROR;
                                res.response_code = fur_pkg::RC_FLASH;
                            end
                            else
                            begin
                                phase_next        = fur_pkg::PH_READY;
                                res.response_code = fur_pkg::RC_OK;
                            end
                        end
                    end
                end
                fur_pkg::CMD_DATA:
                begin
                    if (!active)
                    begin
                        res.response_code = fur_pkg::RC_ERROR;
                        res.resp_seq      = cq_data.seq;
                    end
                    else
                    begin
                        phase_next      = fur_pkg::PH_RECEIVING;
                        idle_ticks_next = '0;
                        if (cq_data.seq < next_seq_reg)
                        begin
                            // duplicate: acknowledge without writing
                            res.response_code = fur_pkg::RC_OK;
                            res.resp_seq      = cq_data.seq;
                        end
                        else if (cq_data.seq > next_seq_reg)
                        begin
                            if (retries_reg >= retry_limit)
                            begin
                                phase_next = fur_pkg::PH_ERROR;
                                has_res    = 1'b0;
                            end
                            else
                            begin
                                retries_next      = retries_reg + 8'd1;
                                res.response_code = fur_pkg::RC_RESEND;
                                res.resp_seq      = next_seq_reg;
                            end
                        end
                        else
                        begin
                            res.write_enable = 1'b1;
                            res.write_offset = cq_data.offset;
                            res.resp_seq     = cq_data.seq;
                            if (!cq_data.flash_ok)
                            begin
                                phase_next        = fur_pkg::PH_ERROR;
                                res.response_code = fur_pkg::RC_FLASH;
                            end
                            else
                            begin
                                received_bytes_next = received_bytes_reg
                                                      + {16'd0, cq_data.payload_len};
                                next_seq_next       = next_seq_reg + 16'd1;
                                retries_next        = '0;
                                res.response_code   = fur_pkg::RC_OK;
                            end
                        end
                    end
                end
                fur_pkg::CMD_END:
                begin
                    if (phase_reg != fur_pkg::PH_RECEIVING)
                    begin
                        res.response_code = fur_pkg::RC_ERROR;
                    end
                    else if (received_bytes_reg != stored_size_reg)
                    begin
                        phase_next        = fur_pkg::PH_ERROR;
                        res.response_code = fur_pkg::RC_SIZE;
                    end
                    else
                    begin
                        phase_next        = fur_pkg::PH_VERIFY;
                        res.response_code = fur_pkg::RC_OK;
                    end
                end
                fur_pkg::CMD_VERIFY:
                begin
                    if (phase_reg != fur_pkg::PH_VERIFY)
                    begin
                        res.response_code = fur_pkg::RC_ERROR;
                    end
                    else if (cq_data.computed_crc == stored_crc_reg)
                    begin
                        phase_next        = fur_pkg::PH_COMPLETE;
                        res.response_code = fur_pkg::RC_OK;
                    end
                    else
                    begin
                        phase_next        = fur_pkg::PH_ERROR;
                        res.response_code = fur_pkg::RC_VERIFY;
                    end
                end
                fur_pkg::CMD_REBOOT:
                begin
                    if (phase_reg != fur_pkg::PH_COMPLETE)
                    begin
                        res.response_code = fur_pkg::RC_ERROR;
                    end
                    else
                    begin
                        res.reboot_request = 1'b1;
                        res.response_code  = fur_pkg::RC_OK;
                    end
                end
                fur_pkg::CMD_ABORT:
                begin
                    phase_next          = fur_pkg::PH_IDLE;
                    stored_size_next    = '0;
                    stored_crc_next     = '0;
                    next_seq_next       = '0;
                    received_bytes_next = '0;
                    retries_next        = '0;
                    idle_ticks_next     = '0;
                    res.response_code   = fur_pkg::RC_OK;
                end
                default:
                begin
                    // unknown command
                    res.response_code = fur_pkg::RC_ERROR;
                    res.resp_seq      = cq_data.seq;
                end
            endcase
        end
        res.phase_out = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= fur_pkg::PH_IDLE;
            stored_size_reg    <= '0;
            stored_crc_reg     <= '0;
            next_seq_reg       <= '0;
            received_bytes_reg <= '0;
            retries_reg        <= '0;
            idle_ticks_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            stored_size_reg    <= stored_size_next;
            stored_crc_reg     <= stored_crc_next;
            next_seq_reg       <= next_seq_next;
            received_bytes_reg <= received_bytes_next;
            retries_reg        <= retries_next;
            idle_ticks_reg     <= idle_ticks_next;
        end
    end

    fur_fifo #(
        .WIDTH ($bits(fur_pkg::res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (advance && has_res),
        .wr_data (res),
        .full    (rq_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    a_write_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && has_res && res.write_enable) |-> (res.resp_command == fur_pkg::CMD_DATA))
        else $error("write strobe on a non-data result");

    a_reboot_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && has_res && res.reboot_request)
        |-> (phase_reg == fur_pkg::PH_COMPLETE && res.response_code == fur_pkg::RC_OK))
        else $error("reboot granted outside complete phase");

    a_erase_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && has_res && res.erase_enable)
        |-> (res.phase_out == fur_pkg::PH_READY || res.phase_out == fur_pkg::PH_ERROR))
        else $error("erase without entering ready or error");

    a_abort_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cq_data.is_tick && cq_data.crc_ok && cq_data.command == fur_pkg::CMD_ABORT)
        |=> (phase_reg == fur_pkg::PH_IDLE && next_seq_reg == 16'd0 && retries_reg == 8'd0))
        else $error("abort did not clear the transfer state");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the firmware update receiver phase controller.
`timescale 1ns / 1ps

module testbench;

    // Command codes the package leaves unnamed: both must answer error.
    localparam logic [2:0] CMD_UNKNOWN  = 3'd6;
    localparam logic [2:0] CMD_RESERVED = 3'd7;
    localparam logic       KIND_PACKET  = 1'b0;
    localparam logic       KIND_TICK    = 1'b1;

    // Timeout reckoned from the slowest run: ~1.6k items, each with its
    // worst gap, worst receiver stall and queue latency, times several.
    localparam int CYCLE_LIMIT  = 1000000;
    // Two queues of QUEUE_DEPTH plus the sequencer, with margin.
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 225;

    // One transaction on the input side.
    typedef struct packed {
        logic        kind;
        logic [2:0]  command;
        logic        crc_ok;
        logic [15:0] seq;
        logic [15:0] payload_len;
        logic [31:0] image_size;
        logic [31:0] image_crc;
        logic        flash_ok;
        logic [31:0] computed_crc;
    } in_item_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // Config port
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [fur_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [fur_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [fur_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // Input side: the item on the wire is held in one struct register
    logic     push    = 1'b0;
    logic     full;
    in_item_t on_wire = '0;

    // Result side
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  resp_command;
    logic [2:0]  response_code;
    logic [15:0] resp_seq;
    logic        write_enable;
    logic [23:0] write_offset;
    logic        erase_enable;
    logic        reboot_request;
    logic [2:0]  phase_out;

    firmware_update_receiver_fsm_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .push           (push),
        .full           (full),
        .kind           (on_wire.kind),
        .command        (on_wire.command),
        .crc_ok         (on_wire.crc_ok),
        .seq            (on_wire.seq),
        .payload_len    (on_wire.payload_len),
        .image_size     (on_wire.image_size),
        .image_crc      (on_wire.image_crc),
        .flash_ok       (on_wire.flash_ok),
        .computed_crc   (on_wire.computed_crc),
        .empty          (empty),
        .pop            (pop),
        .resp_command   (resp_command),
        .response_code  (response_code),
        .resp_seq       (resp_seq),
        .write_enable   (write_enable),
        .write_offset   (write_offset),
        .erase_enable   (erase_enable),
        .reboot_request (reboot_request),
        .phase_out      (phase_out)
    );

    // ------------------------------------------------------------------
    // Receiver mirror: registers and transfer state, reset values
    // ------------------------------------------------------------------
    logic [7:0]  cfg_retry_limit   = fur_pkg::RETRY_LIMIT_RST;
    logic [31:0] cfg_timeout_ticks = fur_pkg::TIMEOUT_TICKS_RST;
    logic [24:0] cfg_max_image     = fur_pkg::MAX_IMAGE_RST;

    logic [2:0]  xfer_phase    = fur_pkg::PH_IDLE;
    logic [31:0] xfer_size     = '0;
    logic [31:0] xfer_crc      = '0;
    logic [15:0] xfer_next_seq = '0;
    logic [31:0] xfer_received = '0;
    logic [7:0]  xfer_retries  = '0;
    logic [31:0] xfer_idle     = '0;

    // Bookkeeping
    in_item_t      packet_queue[$];        // stimulus not yet on the wire
    fur_pkg::res_t expected_responses[$];  // predicted, not yet popped
    int            unaccepted_count = 0;   // queued but not yet taken by the block
    int            phase_items      = 0;
    int            error_count      = 0;
    int            cycle_count      = 0;
    bit            send_steady      = 1'b0;
    bit            pop_steady       = 1'b0;
    int            burst_left       = 0;
    int            gap_left         = 0;
    int            stall_left       = 0;
    bit            has_response;
    fur_pkg::res_t predicted;
    fur_pkg::res_t oldest;

    task automatic clear_transfer();
        xfer_phase    = fur_pkg::PH_IDLE;
        xfer_size     = '0;
        xfer_crc      = '0;
        xfer_next_seq = '0;
        xfer_received = '0;
        xfer_retries  = '0;
        xfer_idle     = '0;
    endtask

    // Advance the mirror by one accepted transaction; answered is low when
    // the transaction yields no response (plain ticks, retry overflow).
    task automatic receiver_step(input in_item_t it, output bit answered,
                                 output fur_pkg::res_t r);
        r        = '0;
        answered = 1'b0;
        if (it.kind == KIND_TICK)
        begin
            // Ticks only matter while a transfer is open.
            if (xfer_phase == fur_pkg::PH_READY || xfer_phase == fur_pkg::PH_RECEIVING)
            begin
                if (xfer_idle != 32'hFFFF_FFFF)
                    xfer_idle++;
                if (xfer_idle > cfg_timeout_ticks)
                begin
                    clear_transfer();
                    answered        = 1'b1;
                    r.resp_command  = fur_pkg::CMD_ABORT;
                    r.response_code = fur_pkg::RC_OK;
                end
            end
        end
        else if (!it.crc_ok)
        begin
            // Corrupt packet: state untouched, ask for next_seq.
            answered        = 1'b1;
            r.resp_command  = it.command;
            r.response_code = fur_pkg::RC_CRC;
            r.resp_seq      = xfer_next_seq;
        end
        else
        begin
            answered        = 1'b1;
            r.resp_command  = it.command;
            r.response_code = fur_pkg::RC_OK;
            case (it.command)
                fur_pkg::CMD_START:
                begin
                    if (it.payload_len != fur_pkg::START_PAYLOAD_LEN)
                    begin
                        r.response_code = fur_pkg::RC_SIZE;
                    end
                    else
                    begin
                        // size and CRC latch even if the size is refused
                        xfer_size = it.image_size;
                        xfer_crc  = it.image_crc;
                        if (it.image_size == 0 || it.image_size > {7'd0, cfg_max_image})
                        begin
                            r.response_code = fur_pkg::RC_SIZE;
                        end
                        else
                        begin
                            xfer_next_seq  = '0;
                            xfer_received  = '0;
                            xfer_retries   = '0;
                            xfer_idle      = '0;
                            r.erase_enable = 1'b1;
                            if (!it.flash_ok)
                            begin
                                xfer_phase      = fur_pkg::PH_ERROR;
                                r.response_code = fur_pkg::RC_FLASH;
                            end
                            else
                            begin
                                xfer_phase = fur_pkg::PH_READY;
                            end
                        end
                    end
                end
                fur_pkg::CMD_DATA:
                begin
                    r.resp_seq = it.seq;
                    if (xfer_phase != fur_pkg::PH_READY
                        && xfer_phase != fur_pkg::PH_RECEIVING)
                    begin
                        r.response_code = fur_pkg::RC_ERROR;
                    end
                    else
                    begin
                        xfer_phase = fur_pkg::PH_RECEIVING;
                        xfer_idle  = '0;
                        if (it.seq > xfer_next_seq)
                        begin
                            if (xfer_retries >= cfg_retry_limit)
                            begin
                                // out of retries: silent move to error
                                xfer_phase = fur_pkg::PH_ERROR;
                                answered   = 1'b0;
                            end
                            else
                            begin
                                xfer_retries++;
                                r.response_code = fur_pkg::RC_RESEND;
                                r.resp_seq      = xfer_next_seq;
                            end
                        end
                        else if (it.seq == xfer_next_seq)
                        begin
                            // in order: the write strobe fires even on flash failure
                            r.write_enable = 1'b1;
                            r.write_offset = 24'(32'(it.seq) * fur_pkg::CHUNK_BYTES);
                            if (!it.flash_ok)
                            begin
                                xfer_phase      = fur_pkg::PH_ERROR;
                                r.response_code = fur_pkg::RC_FLASH;
                            end
                            else
                            begin
                                xfer_received = xfer_received + 32'(it.payload_len);
                                xfer_next_seq++;
                                xfer_retries  = '0;
                            end
                        end
                        // an old sequence is acknowledged with no write
                    end
                end
                fur_pkg::CMD_END:
                begin
                    if (xfer_phase != fur_pkg::PH_RECEIVING)
                    begin
                        r.response_code = fur_pkg::RC_ERROR;
                    end
                    else if (xfer_received != xfer_size)
                    begin
                        xfer_phase      = fur_pkg::PH_ERROR;
                        r.response_code = fur_pkg::RC_SIZE;
                    end
                    else
                    begin
                        xfer_phase = fur_pkg::PH_VERIFY;
                    end
                end
                fur_pkg::CMD_VERIFY:
                begin
                    if (xfer_phase != fur_pkg::PH_VERIFY)
                    begin
                        r.response_code = fur_pkg::RC_ERROR;
                    end
                    else if (it.computed_crc == xfer_crc)
                    begin
                        xfer_phase = fur_pkg::PH_COMPLETE;
                    end
                    else
                    begin
                        xfer_phase      = fur_pkg::PH_ERROR;
                        r.response_code = fur_pkg::RC_VERIFY;
                    end
                end
                fur_pkg::CMD_REBOOT:
                begin
                    if (xfer_phase != fur_pkg::PH_COMPLETE)
                        r.response_code = fur_pkg::RC_ERROR;
                    else
                        r.reboot_request = 1'b1;
                end
                fur_pkg::CMD_ABORT:
                begin
                    clear_transfer();
                end
                default:
                begin
                    r.response_code = fur_pkg::RC_ERROR;
                    r.resp_seq      = it.seq;
                end
            endcase
        end
        r.phase_out = xfer_phase;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length, random gaps; a held item stays
    // on the wire until the block takes it.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                receiver_step(on_wire, has_response, predicted);
                if (has_response)
                    expected_responses.push_back(predicted);
                unaccepted_count--;
            end
            if (!push || !full)
            begin
                if (gap_left > 0 || packet_queue.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    push <= 1'b0;
                end
                else
                begin
                    on_wire <= packet_queue.pop_front();
                    push    <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        if (send_steady)
                            gap_left = 0;
                        else if ($urandom_range(0, 9) == 0)
                            gap_left = $urandom_range(10, 30);
                        else
                            gap_left = $urandom_range(0, 6);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each popped transaction against the oldest
    // prediction; pop stalls come in short random runs.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_responses.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, %s %0d code %0d seq %0h",
                             $time, "actual cmd", resp_command, response_code, resp_seq);
                    error_count++;
                end
                else
                begin
                    oldest = expected_responses.pop_front();
                    check_field("resp_command", 32'(oldest.resp_command), 32'(resp_command));
                    check_field("response_code", 32'(oldest.response_code),
                                32'(response_code));
                    check_field("resp_seq", 32'(oldest.resp_seq), 32'(resp_seq));
                    check_field("write_enable", 32'(oldest.write_enable), 32'(write_enable));
                    check_field("write_offset", 32'(oldest.write_offset), 32'(write_offset));
                    check_field("erase_enable", 32'(oldest.erase_enable), 32'(erase_enable));
                    check_field("reboot_request", 32'(oldest.reboot_request),
                                32'(reboot_request));
                    check_field("phase_out", 32'(oldest.phase_out), 32'(phase_out));
                end
            end
            if (pop_steady)
            begin
                pop <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 14);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic in_item_t make_packet(input logic [2:0] cmd, input logic [15:0] sq,
                                             input logic [15:0] len);
        in_item_t it;
        it.kind         = KIND_PACKET;
        it.command      = cmd;
        it.crc_ok       = 1'b1;
        it.seq          = sq;
        it.payload_len  = len;
        it.image_size   = $urandom;
        it.image_crc    = $urandom;
        it.flash_ok     = 1'b1;
        it.computed_crc = $urandom;
        return it;
    endfunction

    task automatic queue_item(input in_item_t it);
        packet_queue.push_back(it);
        unaccepted_count++;
        phase_items++;
    endtask

    // Ticks carry random junk in the packet fields.
    task automatic queue_ticks(input int count);
        in_item_t it;
        repeat (count)
        begin
            it          = make_packet(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
            it.kind     = KIND_TICK;
            it.crc_ok   = 1'($urandom);
            it.flash_ok = 1'($urandom);
            queue_item(it);
        end
    endtask

    // Anything goes: random kind, command, flags and fields.
    task automatic queue_noise();
        in_item_t it;
        it = make_packet(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
        it.kind     = ($urandom_range(0, 4) == 0) ? KIND_TICK : KIND_PACKET;
        it.crc_ok   = ($urandom_range(0, 5) != 0);
        it.flash_ok = 1'($urandom);
        if ($urandom_range(0, 2) == 0)
            it.payload_len = fur_pkg::START_PAYLOAD_LEN;
        if ($urandom_range(0, 3) == 0)
            it.image_size = $urandom_range(0, 32'(cfg_max_image) + 1);
        queue_item(it);
    endtask

    // Now and then something odd ahead of data chunk n: bad CRC, skip-ahead,
    // duplicate (when n > 0), idle ticks, abort or garbage.
    task automatic queue_disturbance(input int n);
        in_item_t    it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            it        = make_packet(fur_pkg::CMD_DATA, 16'(n), 16'($urandom));
            it.crc_ok = 1'b0;
            queue_item(it);
        end
        else if (pick < 14)
        begin
            queue_item(make_packet(fur_pkg::CMD_DATA, 16'(n + $urandom_range(1, 3)),
                                   16'($urandom)));
        end
        else if (pick < 20 && n > 0)
        begin
            queue_item(make_packet(fur_pkg::CMD_DATA, 16'($urandom_range(0, n - 1)),
                                   16'($urandom)));
        end
        else if (pick < 28)
        begin
            queue_ticks($urandom_range(1, 4));
        end
        else if (pick < 30)
        begin
            queue_ticks($urandom_range(5, 60));
        end
        else if (pick < 32)
        begin
            queue_item(make_packet(fur_pkg::CMD_ABORT, 16'($urandom), 16'($urandom)));
        end
        else if (pick < 34)
        begin
            queue_noise();
        end
    endtask

    // A well-formed transfer (start, chunks, end, verify, reboot) with
    // occasional faults mixed in.
    task automatic queue_transfer();
        int unsigned total;
        int unsigned left;
        int unsigned chunk;
        int unsigned cap;
        int          n;
        logic [31:0] image_crc_val;
        in_item_t    it;
        cap           = (cfg_max_image < 25'd600) ? 32'(cfg_max_image) : 600;
        total         = $urandom_range(1, cap);
        image_crc_val = $urandom;
        it            = make_packet(fur_pkg::CMD_START, 16'($urandom),
                                    fur_pkg::START_PAYLOAD_LEN);
        it.image_size = total;
        it.image_crc  = image_crc_val;
        if ($urandom_range(0, 24) == 0)
            it.flash_ok = 1'b0;
        if ($urandom_range(0, 24) == 0)
            it.image_size = $urandom;
        queue_item(it);
        left = total;
        n    = 0;
        while (left > 0)
        begin
            chunk = $urandom_range(1, fur_pkg::CHUNK_BYTES);
            if (chunk > left)
                chunk = left;
            queue_disturbance(n);
            it = make_packet(fur_pkg::CMD_DATA, 16'(n), 16'(chunk));
            if ($urandom_range(0, 49) == 0)
                it.flash_ok = 1'b0;
            if ($urandom_range(0, 49) == 0)
                it.payload_len = 16'(chunk + 1);   // byte count will not add up
            queue_item(it);
            left -= chunk;
            n++;
        end
        if ($urandom_range(0, 9) == 0)
            queue_ticks($urandom_range(1, 3));
        queue_item(make_packet(fur_pkg::CMD_END, 16'($urandom), 16'($urandom)));
        it = make_packet(fur_pkg::CMD_VERIFY, 16'($urandom), 16'($urandom));
        it.computed_crc = ($urandom_range(0, 9) == 0) ? 32'($urandom) : image_crc_val;
        queue_item(it);
        repeat ($urandom_range(0, 2))
            queue_item(make_packet(fur_pkg::CMD_REBOOT, 16'($urandom), 16'($urandom)));
    endtask

    // Idle point: every item taken, every response popped, then a wait for
    // transactions that answer nothing.
    task automatic wait_until_drained();
        do
            @(posedge clk);
        while (unaccepted_count != 0 || expected_responses.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write, then read back. Mirror updates at the write edge.
    task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] held;
        if (idx == fur_pkg::REG_RETRY_LIMIT)
            held = {24'd0, value[7:0]};
        else if (idx == fur_pkg::REG_MAX_IMAGE)
            held = {7'd0, value[24:0]};
        else
            held = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == fur_pkg::REG_RETRY_LIMIT)
            cfg_retry_limit = held[7:0];
        else if (idx == fur_pkg::REG_TIMEOUT_TICKS)
            cfg_timeout_ticks = held;
        else
            cfg_max_image = held[24:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("register readback", held, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        in_item_t    it;
        logic [7:0]  retry_val;
        logic [31:0] timeout_val;
        logic [24:0] max_val;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset register values (retry 3, timeout 5000, max 64 KiB).
        queue_ticks(1);                                          // tick while idle: nothing
        queue_item(make_packet(fur_pkg::CMD_DATA, 16'hFFFF, 16'hFFFF));   // data while idle
        queue_item(make_packet(CMD_UNKNOWN, 16'h1234, 16'd0));
        queue_item(make_packet(CMD_RESERVED, 16'hABCD, 16'd0));
        it        = make_packet(fur_pkg::CMD_START, 16'd0, fur_pkg::START_PAYLOAD_LEN);
        it.crc_ok = 1'b0;                                        // corrupt packet
        queue_item(it);
        queue_item(make_packet(fur_pkg::CMD_START, 16'd0, 16'd7));   // wrong start length
        it            = make_packet(fur_pkg::CMD_START, 16'd0, fur_pkg::START_PAYLOAD_LEN);
        it.image_size = 32'd0;                                   // empty image
        queue_item(it);
        it.image_size = 32'(fur_pkg::MAX_IMAGE_RST) + 1;         // one byte too big
        queue_item(it);
        it.image_size = 32'hFFFF_FFFF;
        queue_item(it);
        it.image_size = 32'd256;
        it.flash_ok   = 1'b0;                                    // erase fails
        queue_item(it);
        queue_item(make_packet(fur_pkg::CMD_END, 16'd0, 16'd0));     // end in error phase
        // Clean 256-byte transfer with resend, duplicate and bad CRC on the way.
        it.flash_ok  = 1'b1;
        it.image_crc = 32'hC0FF_EE01;
        queue_item(it);
        queue_ticks(1);
        queue_item(make_packet(fur_pkg::CMD_DATA, 16'd1, 16'd128));  // ahead: resend 0
        queue_item(make_packet(fur_pkg::CMD_DATA, 16'd0, 16'd128));
        queue_item(make_packet(fur_pkg::CMD_DATA, 16'd0, 16'd128));  // duplicate
        it        = make_packet(fur_pkg::CMD_DATA, 16'd1, 16'd128);
        it.crc_ok = 1'b0;
        queue_item(it);
        queue_item(make_packet(fur_pkg::CMD_VERIFY, 16'd0, 16'd0));  // verify too early
        it.crc_ok = 1'b1;
        queue_item(it);
        queue_item(make_packet(fur_pkg::CMD_END, 16'd0, 16'd0));
        it              = make_packet(fur_pkg::CMD_VERIFY, 16'd0, 16'd0);
        it.computed_crc = 32'hC0FF_EE01;
        queue_item(it);
        queue_ticks(1);                                          // tick in complete: nothing
        queue_item(make_packet(fur_pkg::CMD_REBOOT, 16'd0, 16'd0));
        queue_item(make_packet(fur_pkg::CMD_ABORT, 16'hFFFF, 16'hFFFF));
        queue_item(make_packet(fur_pkg::CMD_REBOOT, 16'd0, 16'd0));  // reboot while idle
        // Largest size; skip-ahead until the retry budget runs out (silent).
        it            = make_packet(fur_pkg::CMD_START, 16'd0, fur_pkg::START_PAYLOAD_LEN);
        it.image_size = 32'(fur_pkg::MAX_IMAGE_RST);
        queue_item(it);
        repeat (4) queue_item(make_packet(fur_pkg::CMD_DATA, 16'd5, 16'd1));
        // Program failure still strobes the write.
        queue_item(it);
        it          = make_packet(fur_pkg::CMD_DATA, 16'd0, 16'hFFFF);
        it.flash_ok = 1'b0;
        queue_item(it);
        // Short image: end too early, then a CRC mismatch at verify.
        it            = make_packet(fur_pkg::CMD_START, 16'd0, fur_pkg::START_PAYLOAD_LEN);
        it.image_size = 32'd100;
        queue_item(it);
        queue_item(make_packet(fur_pkg::CMD_DATA, 16'd0, 16'd50));
        queue_item(make_packet(fur_pkg::CMD_END, 16'd0, 16'd0));
        queue_item(it);
        queue_item(make_packet(fur_pkg::CMD_DATA, 16'd0, 16'd100));
        queue_item(make_packet(fur_pkg::CMD_END, 16'd0, 16'd0));
        it              = make_packet(fur_pkg::CMD_VERIFY, 16'd0, 16'd0);
        it.computed_crc = ~it.image_crc;
        queue_item(it);
        // Idle ticks well below the reset threshold: counted, no abort.
        it            = make_packet(fur_pkg::CMD_START, 16'd0, fur_pkg::START_PAYLOAD_LEN);
        it.image_size = 32'd10;
        queue_item(it);
        queue_ticks(4);
        wait_until_drained();

        // Random transfers under several register settings, extremes first.
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    retry_val   = 8'd0;
                    timeout_val = 32'd0;
                    max_val     = 25'd1;
                end
                1:
                begin
                    retry_val   = 8'd255;
                    timeout_val = 32'hFFFF_FFFF;
                    max_val     = 25'd16777216;
                end
                2:
                begin
                    retry_val   = 8'd2;
                    timeout_val = 32'd10;
                    max_val     = 25'd4096;
                end
                default:
                begin
                    retry_val   = 8'($urandom_range(0, 5));
                    timeout_val = $urandom_range(1, 40);
                    max_val     = 25'($urandom_range(200, 3000));
                end
            endcase
            program_register(fur_pkg::REG_RETRY_LIMIT, {24'd0, retry_val});
            program_register(fur_pkg::REG_TIMEOUT_TICKS, timeout_val);
            program_register(fur_pkg::REG_MAX_IMAGE, {7'd0, max_val});
            // some phases run flat out on one or both sides
            send_steady = (p == 1 || p == 3);
            pop_steady  = (p == 1 || p == 4);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 8)
                    queue_transfer();
                else
                    repeat ($urandom_range(1, 5)) queue_noise();
            end
            wait_until_drained();
        end

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
